[design/gecb_pkg.sv]
`timescale 1ns / 1ps

package gecb_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int POS_WIDTH_DEF = 48;

  // Command queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd1;

  localparam logic [1:0]  MODE_RESET     = 2'd0;
  localparam logic [10:0] CAPACITY_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_BEGIN  = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RM_WRITE = 2'd0,
    RM_TOUCH = 2'd1,
    RM_LATCH = 2'd2
  } rec_mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IDLE      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_BACKWARD  = 3'd3,
    ST_FULL      = 3'd4,
    ST_REJECT    = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] tick_position;
    logic [31:0] sample_bits;
    logic        gesture_held;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] point_count;
    logic [31:0] drop_count;
    logic [47:0] out_position;
    logic [31:0] out_value_bits;
    logic        is_recording;
  } out_item_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    func_t       op;
    logic        nonfinite;
    logic [47:0] pos;
    logic [31:0] bits;
    logic        held;
    logic [9:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

[design/gecb_front.sv]
`timescale 1ns / 1ps

module gecb_front (
  input  gecb_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                q_ready,
  output gecb_pkg::cmd_beat_t push
);

  gecb_pkg::cmd_t cmd;

  always_comb begin
    cmd.op   = gecb_pkg::func_t'(in_data.func);
    // A sample whose exponent is all ones is infinite or NaN.
    cmd.nonfinite = (in_data.sample_bits[30:23] == 8'hFF);
    cmd.pos  = in_data.tick_position;
    cmd.bits = in_data.sample_bits;
    cmd.held = in_data.gesture_held;
    cmd.idx  = in_data.read_index;
  end

  assign push.valid = in_valid;
  assign push.cmd   = cmd;
  assign in_stall   = !q_ready;

endmodule

[design/gecb_queue.sv]
`timescale 1ns / 1ps

module gecb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  gecb_pkg::cmd_beat_t push,
  output logic                push_ready,
  output gecb_pkg::cmd_beat_t head,
  input  logic                pop
);

  gecb_pkg::cmd_t entry_r [gecb_pkg::QDEPTH];

  logic [gecb_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gecb_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gecb_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != gecb_pkg::Q_CNT_W'(gecb_pkg::QDEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == gecb_pkg::Q_PTR_W'(gecb_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gecb_pkg::Q_PTR_W'(gecb_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gecb_pkg::Q_CNT_W'(gecb_pkg::QDEPTH))
    else $error("command queue holds more beats than its depth");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.valid && count_r == gecb_pkg::Q_CNT_W'(1)) |=> !head.valid)
    else $error("queue did not drain after its last beat was popped");

endmodule

[design/gecb_back.sv]
`timescale 1ns / 1ps

module gecb_back #(
  parameter int DEPTH     = gecb_pkg::DEPTH_DEF,
  parameter int POS_WIDTH = gecb_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gecb_pkg::cmd_beat_t                 head,
  output logic                                pop,
  input  logic                                cfg_valid,
  input  logic [gecb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gecb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gecb_pkg::out_item_t                 out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [POS_WIDTH-1:0] pos_mem [DEPTH];
  logic [31:0]          val_mem [DEPTH];

  gecb_pkg::back_state_t state_r, state_nxt;

  logic [1:0]           mode_r;
  logic [10:0]          cap_r;
  logic [CNT_W-1:0]     stored_count_r, stored_count_nxt;
  logic [POS_WIDTH-1:0] newest_r, newest_nxt;
  logic                 session_r, session_nxt;
  logic                 gesture_before_r, gesture_before_nxt;
  logic                 latch_armed_r, latch_armed_nxt;
  logic [31:0]          held_value_r, held_value_nxt;
  logic [31:0]          dropped_r, dropped_nxt;
  logic                 out_valid_r, out_valid_nxt;
  gecb_pkg::out_item_t  out_data_r, out_data_nxt;
  logic [POS_WIDTH-1:0] rd_pos_r;
  logic [31:0]          rd_val_r;

  logic                 slot_free, load, do_store, has_points, full;
  logic                 pos_we, val_we, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr, last_addr;
  logic [POS_WIDTH-1:0] pos_in;
  logic [31:0]          sbits;
  gecb_pkg::status_t    st;

  assign slot_free  = !out_valid_r || !out_stall;
  assign pos_in     = POS_WIDTH'(head.cmd.pos);
  assign has_points = (stored_count_r != '0);
  assign last_addr  = AW'(stored_count_r - 1'b1);
  // Capacity above the memory depth is clamped to the depth.
  assign full       = (stored_count_r == CNT_W'(DEPTH)) ||
                      (32'(stored_count_r) >= 32'(cap_r));

  always_comb begin
    state_nxt          = state_r;
    stored_count_nxt   = stored_count_r;
    newest_nxt         = newest_r;
    session_nxt        = session_r;
    gesture_before_nxt = gesture_before_r;
    latch_armed_nxt    = latch_armed_r;
    held_value_nxt     = held_value_r;
    dropped_nxt        = dropped_r;
    pop      = 1'b0;
    load     = 1'b0;
    do_store = 1'b0;
    sbits    = head.cmd.bits;
    pos_we   = 1'b0;
    val_we   = 1'b0;
    wr_addr  = AW'(stored_count_r);
    rd_en    = 1'b0;
    rd_addr  = AW'(head.cmd.idx);
    st       = gecb_pkg::ST_OK;

    unique case (state_r)
      gecb_pkg::BK_EXEC: begin
        if (head.valid && slot_free) begin
          pop  = 1'b1;
          load = 1'b1;
          unique case (head.cmd.op)
            gecb_pkg::FUNC_RECORD: begin
              if (!session_r) begin
                st = gecb_pkg::ST_IDLE;
              end else if (head.cmd.nonfinite) begin
                st = gecb_pkg::ST_INVALID;
              end else begin
                case (mode_r)
                  gecb_pkg::RM_WRITE: begin
                    do_store = 1'b1;
                  end
                  gecb_pkg::RM_TOUCH: begin
                    do_store = head.cmd.held || gesture_before_r;
                  end
                  gecb_pkg::RM_LATCH: begin
                    if (head.cmd.held) begin
                      latch_armed_nxt = 1'b1;
                      held_value_nxt  = head.cmd.bits;
                    end
                    do_store = head.cmd.held || latch_armed_r;
                    sbits    = head.cmd.held ? head.cmd.bits : held_value_r;
                  end
                  default: begin
                  end
                endcase
                gesture_before_nxt = head.cmd.held;
                if (do_store) begin
                  if (has_points && pos_in < newest_r) begin
                    st = gecb_pkg::ST_BACKWARD;
                  end else if (has_points && pos_in == newest_r) begin
                    // Same position again: replace the newest value, even when full.
                    val_we  = 1'b1;
                    wr_addr = last_addr;
                  end else if (full) begin
                    st = gecb_pkg::ST_FULL;
                    if (dropped_r != '1) begin
                      dropped_nxt = dropped_r + 1'b1;
                    end
                  end else begin
                    pos_we           = 1'b1;
                    val_we           = 1'b1;
                    stored_count_nxt = stored_count_r + 1'b1;
                    newest_nxt       = pos_in;
                  end
                end
              end
            end
            gecb_pkg::FUNC_BEGIN: begin
              if (session_r) begin
                st = gecb_pkg::ST_REJECT;
              end else begin
                stored_count_nxt   = '0;
                held_value_nxt     = '0;
                gesture_before_nxt = 1'b0;
                latch_armed_nxt    = 1'b0;
                session_nxt        = 1'b1;
              end
            end
            gecb_pkg::FUNC_END: begin
              if (!session_r) begin
                st = gecb_pkg::ST_REJECT;
              end else begin
                session_nxt        = 1'b0;
                gesture_before_nxt = 1'b0;
                latch_armed_nxt    = 1'b0;
              end
            end
            gecb_pkg::FUNC_READ: begin
              if (32'(head.cmd.idx) >= 32'(stored_count_r)) begin
                st = gecb_pkg::ST_BAD_INDEX;
              end else begin
                // The result goes out once the registered read data is back.
                rd_en     = 1'b1;
                load      = 1'b0;
                state_nxt = gecb_pkg::BK_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gecb_pkg::BK_READ: begin
        load      = 1'b1;
        state_nxt = gecb_pkg::BK_EXEC;
      end
      default: begin
        state_nxt = gecb_pkg::BK_EXEC;
      end
    endcase

    out_data_nxt.status         = st;
    out_data_nxt.point_count    = 11'(stored_count_nxt);
    out_data_nxt.drop_count     = dropped_nxt;
    out_data_nxt.out_position   = (state_r == gecb_pkg::BK_READ) ? 48'(rd_pos_r) : '0;
    out_data_nxt.out_value_bits = (state_r == gecb_pkg::BK_READ) ? rd_val_r : '0;
    out_data_nxt.is_recording   = session_nxt;

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gecb_pkg::BK_EXEC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_count_r   <= '0;
      newest_r         <= '0;
      session_r        <= 1'b0;
      gesture_before_r <= 1'b0;
      latch_armed_r    <= 1'b0;
      held_value_r     <= '0;
      dropped_r        <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      stored_count_r   <= stored_count_nxt;
      newest_r         <= newest_nxt;
      session_r        <= session_nxt;
      gesture_before_r <= gesture_before_nxt;
      latch_armed_r    <= latch_armed_nxt;
      held_value_r     <= held_value_nxt;
      dropped_r        <= dropped_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gecb_pkg::MODE_RESET;
      cap_r  <= gecb_pkg::CAPACITY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == gecb_pkg::CFG_IDX_MODE) begin
        mode_r <= cfg_data[1:0];
      end else if (cfg_index == gecb_pkg::CFG_IDX_CAPACITY) begin
        cap_r <= cfg_data[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= pos_in;
    end
    if (val_we) begin
      val_mem[wr_addr] <= sbits;
    end
    if (rd_en) begin
      rd_pos_r <= pos_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_count_r) <= 32'(DEPTH))
    else $error("stored point count exceeds the memory depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gecb_pkg::BK_READ) |-> !out_valid_r)
    else $error("read data returned while the output register was occupied");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !session_r |-> (!latch_armed_r && !gesture_before_r))
    else $error("gesture or latch state left armed outside a session");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (dropped_r >= $past(dropped_r)))
    else $error("drop counter moved backwards");

endmodule

[design/gated_event_capture_buffer_core.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Beat
// ---------+-----------+--------------------+-------------------------------
// in_      | input     | in_valid/in_stall  | gecb_pkg::in_item_t
// out_     | output    | out_valid/out_stall| gecb_pkg::out_item_t
// cfg_     | input     | cfg_valid/cfg_ready| register index and write data
//
// Record, begin and end commands load their result directly; a read of a stored
// point waits in BK_READ for the registered read port of the point memory.
// A two-beat command queue separates input acceptance from execution, so while a
// result waits in the output register the input accepts until the queue is full.
// Reset is synchronous and active low; the point memory is not cleared. cfg_ready
// is always high; the user writes configuration only while idle, unchecked.

module gated_event_capture_buffer_core #(
  parameter int DEPTH     = gecb_pkg::DEPTH_DEF,
  parameter int POS_WIDTH = gecb_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gecb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gecb_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gecb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gecb_pkg::CFG_DATA_W-1:0] cfg_data
);

  gecb_pkg::cmd_beat_t push, head;
  logic                q_ready, pop;

  assign cfg_ready = 1'b1;

  gecb_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_ready  (q_ready),
    .push     (push)
  );

  gecb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .head       (head),
    .pop        (pop)
  );

  gecb_back #(
    .DEPTH     (DEPTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
